>>> hw/rtl/bbhd_pkg.sv
// Shared types, constants and helpers for the bus boot handshake detector.
// No dependencies; used by bbhd_step and bus_boot_handshake_detector.
`default_nettype none

package bbhd_pkg;

	localparam int unsigned ADDR_W = 13;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	// Register reset values
	localparam logic [ADDR_W-1:0] DANCE_A_RST = 13'h1f76;
	localparam logic [ADDR_W-1:0] DANCE_B_RST = 13'h1f68;
	localparam logic [ADDR_W-1:0] DANCE_C_RST = 13'h1f74;
	localparam logic [ADDR_W-1:0] DANCE_D_RST = 13'h1f72;
	localparam logic [WORD_W-1:0] FINAL_RST   = 16'h0000;

	// Bus addresses with a fixed meaning in the handshake
	localparam logic [ADDR_W-1:0] ADDR_SKIP   = 13'h1ffe;
	localparam logic [ADDR_W-1:0] ADDR_LOAD   = 13'h1fff;
	localparam int unsigned       ADDR_WIN    = 12;
	localparam logic [WORD_W-1:0] VECTOR_RST  = {8'hff, 8'h74};

	// Stage codes
	localparam logic [CNT_W-1:0] STG_SKIP_LAST = 3'd3;
	localparam logic [CNT_W-1:0] STG_LOAD      = 3'd4;
	localparam logic [CNT_W-1:0] STG_MATCH     = 3'd5;
	localparam logic [CNT_W-1:0] STG_FAILED    = 3'd6;
	localparam logic [CNT_W-1:0] GRP_LAST      = 3'd4;

	// Register indexes
	typedef enum logic [2:0] {
		REG_DANCE_A = 3'd0,
		REG_DANCE_B = 3'd1,
		REG_DANCE_C = 3'd2,
		REG_DANCE_D = 3'd3,
		REG_FINAL   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0] dance_a;
		logic [ADDR_W-1:0] dance_b;
		logic [ADDR_W-1:0] dance_c;
		logic [ADDR_W-1:0] dance_d;
		logic [WORD_W-1:0] final_vector;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  group;
		logic [CNT_W-1:0]  stage;
		logic [WORD_W-1:0] served;
		logic              finished;
	} hs_state_t;

	// Vector word for a group: a, b, c, d, then the program vector
	function automatic logic [WORD_W-1:0] word_for(input cfg_t cfg, input logic [CNT_W-1:0] g);
		logic [WORD_W-1:0] w;
		unique case (g)
			3'd0:    w = {{(WORD_W-ADDR_W){1'b0}}, cfg.dance_a};
			3'd1:    w = {{(WORD_W-ADDR_W){1'b0}}, cfg.dance_b};
			3'd2:    w = {{(WORD_W-ADDR_W){1'b0}}, cfg.dance_c};
			3'd3:    w = {{(WORD_W-ADDR_W){1'b0}}, cfg.dance_d};
			default: w = cfg.final_vector;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bbhd_step.sv
// Next-state logic of the handshake tracker for one observed bus access.
// Depends on bbhd_pkg.
`default_nettype none

module bbhd_step import bbhd_pkg::*; (
	input  wire cfg_t              cfg,
	input  wire hs_state_t         cur,
	input  wire logic [ADDR_W-1:0] addr,
	output hs_state_t              nxt,
	output logic                   changed
);

	logic restart;

	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		restart = 1'b0;
		if (!cur.finished && addr[ADDR_WIN]) begin
			priority if (cur.stage <= STG_SKIP_LAST) begin
				if (addr == ADDR_SKIP) begin
					// skip from the last early stage lands in the next group
					if (cur.stage == STG_SKIP_LAST) begin
						nxt.group = cur.group + 3'd1;
						nxt.stage = '0;
					end else begin
						nxt.stage = STG_LOAD;
					end
				end else if (cur.stage < STG_SKIP_LAST) begin
					nxt.stage = cur.stage + 3'd1;
				end else begin
					restart = 1'b1;
				end
			end else if (cur.stage == STG_LOAD) begin
				if (addr == ADDR_LOAD) begin
					nxt.stage = STG_MATCH;
					if (cur.group < GRP_LAST) begin
						nxt.served = word_for(cfg, cur.group + 3'd1);
						changed    = 1'b1;
					end else if (cur.group == GRP_LAST) begin
						nxt.finished = 1'b1;
					end
				end else begin
					restart = 1'b1;
				end
			end else if (cur.stage == STG_MATCH) begin
				if (cur.group <= GRP_LAST &&
				    {{(WORD_W-ADDR_W){1'b0}}, addr} == word_for(cfg, cur.group)) begin
					nxt.group = cur.group + 3'd1;
					nxt.stage = '0;
				end else begin
					nxt.stage = STG_FAILED;
				end
			end else begin
				restart = 1'b1;
			end

			if (restart) begin
				nxt.group  = '0;
				nxt.stage  = '0;
				nxt.served = {{(WORD_W-ADDR_W){1'b0}}, cfg.dance_a};
				changed    = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bus_boot_handshake_detector.sv
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle while the held result is taken or the output
// register is empty; the tracker state updates at the accepting edge.
// Reset (arst_n low, asynchronous): group and stage zero, vector word 0xFF74,
// done flag clear, registers at their defaults, output empty.
// Top level; depends on bbhd_pkg and bbhd_step.
`default_nettype none

module bus_boot_handshake_detector import bbhd_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire logic [ADDR_W-1:0] bus_address,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [WORD_W-1:0]      vector_word,
	output logic                   vector_changed,
	output logic                   sequence_done,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	cfg_t              cfg_q;
	hs_state_t         st_q;
	hs_state_t         st_nxt;
	logic              chg_nxt;
	logic              out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic              chg_q;
	logic              done_q;
	logic              in_fire;
	logic              cfg_wr;
	logic [2:0]        reg_sel;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign reg_sel  = paddr[APB_AW-1:2];
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dance_a      <= DANCE_A_RST;
			cfg_q.dance_b      <= DANCE_B_RST;
			cfg_q.dance_c      <= DANCE_C_RST;
			cfg_q.dance_d      <= DANCE_D_RST;
			cfg_q.final_vector <= FINAL_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_DANCE_A: cfg_q.dance_a      <= pwdata[ADDR_W-1:0];
				REG_DANCE_B: cfg_q.dance_b      <= pwdata[ADDR_W-1:0];
				REG_DANCE_C: cfg_q.dance_c      <= pwdata[ADDR_W-1:0];
				REG_DANCE_D: cfg_q.dance_d      <= pwdata[ADDR_W-1:0];
				REG_FINAL:   cfg_q.final_vector <= pwdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DANCE_A: prdata = {{(APB_DW-ADDR_W){1'b0}}, cfg_q.dance_a};
			REG_DANCE_B: prdata = {{(APB_DW-ADDR_W){1'b0}}, cfg_q.dance_b};
			REG_DANCE_C: prdata = {{(APB_DW-ADDR_W){1'b0}}, cfg_q.dance_c};
			REG_DANCE_D: prdata = {{(APB_DW-ADDR_W){1'b0}}, cfg_q.dance_d};
			REG_FINAL:   prdata = {{(APB_DW-WORD_W){1'b0}}, cfg_q.final_vector};
			default:     prdata = '0;
		endcase
	end

	bbhd_step u_step (
		.cfg     (cfg_q),
		.cur     (st_q),
		.addr    (bus_address),
		.nxt     (st_nxt),
		.changed (chg_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.group    <= '0;
			st_q.stage    <= '0;
			st_q.served   <= VECTOR_RST;
			st_q.finished <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				st_q <= st_nxt;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q <= st_nxt.served;
			chg_q  <= chg_nxt;
			done_q <= st_nxt.finished;
		end
	end

	assign out_valid      = out_valid_q;
	assign vector_word    = word_q;
	assign vector_changed = chg_q;
	assign sequence_done  = done_q;

	// the held result always mirrors the tracker, since both load on the same accepted item
	a_word_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (word_q == st_q.served && done_q == st_q.finished))
		else $error("held result out of step with tracker state");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.finished |=> st_q.finished)
		else $error("done flag dropped");

	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.finished |-> (st_q.group == GRP_LAST && st_q.stage == STG_MATCH))
		else $error("done flag set outside final group");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.stage <= STG_FAILED)
		else $error("stage counter out of range");

	a_no_change_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && st_q.finished) |=> !chg_q)
		else $error("vector changed after done");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for bus_boot_handshake_detector.
// Drives bus accesses and APB register writes, predicts every result in-line
// and checks it as it leaves the block. Depends on bbhd_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bbhd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int          HOLD_CYCLES = 300;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              changed;
		logic              done;
	} vec_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ADDR_W-1:0] bus_address = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [WORD_W-1:0] vector_word;
	logic              vector_changed;
	logic              sequence_done;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bus_boot_handshake_detector u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bus_address    (bus_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.vector_word    (vector_word),
		.vector_changed (vector_changed),
		.sequence_done  (sequence_done),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #1 clk = ~clk;

	// Tracker copy: configuration and handshake position
	cfg_t              cfg = '{DANCE_A_RST, DANCE_B_RST, DANCE_C_RST, DANCE_D_RST, FINAL_RST};
	logic [CNT_W-1:0]  hs_group = '0;
	logic [CNT_W-1:0]  hs_stage = '0;
	logic [WORD_W-1:0] hs_served = VECTOR_RST;
	logic              hs_done = 1'b0;

	vec_result_t expected_vectors[$];
	int          mismatches = 0;
	int unsigned cycles = 0;

	// Stimulus shaping knobs
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit climbing = 1'b0;
	bit finish_ok = 1'b0;
	int noise_pct = 10;
	int climb_pct = 25;
	int hold_requests = 0;
	int holds_served = 0;
	int rx_hold = 0;
	int rx_stall = 0;

	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] group_word(input logic [CNT_W-1:0] g);
		case (g)
			3'd0:    return WORD_W'(cfg.dance_a);
			3'd1:    return WORD_W'(cfg.dance_b);
			3'd2:    return WORD_W'(cfg.dance_c);
			3'd3:    return WORD_W'(cfg.dance_d);
			default: return cfg.final_vector;
		endcase
	endfunction

	// Advances the tracker by one observed access and returns the result it must show
	function automatic vec_result_t track_access(input logic [ADDR_W-1:0] a);
		vec_result_t r;
		logic        restart;
		r = '0;
		restart = 1'b0;
		if (!hs_done && a[ADDR_WIN]) begin
			if (hs_stage <= STG_SKIP_LAST) begin
				if (a == ADDR_SKIP) begin
					if (hs_stage == STG_SKIP_LAST) begin
						hs_group = hs_group + 3'd1;
						hs_stage = '0;
					end else begin
						hs_stage = STG_LOAD;
					end
				end else if (hs_stage < STG_SKIP_LAST) begin
					hs_stage = hs_stage + 3'd1;
				end else begin
					restart = 1'b1;
				end
			end else if (hs_stage == STG_LOAD) begin
				if (a == ADDR_LOAD) begin
					hs_stage = STG_MATCH;
					if (hs_group < GRP_LAST) begin
						hs_served = group_word(hs_group + 3'd1);
						r.changed = 1'b1;
					end else if (hs_group == GRP_LAST) begin
						hs_done = 1'b1;
					end
				end else begin
					restart = 1'b1;
				end
			end else if (hs_stage == STG_MATCH) begin
				if (hs_group <= GRP_LAST && WORD_W'(a) == group_word(hs_group)) begin
					hs_group = hs_group + 3'd1;
					hs_stage = '0;
				end else begin
					hs_stage = STG_FAILED;
				end
			end else begin
				restart = 1'b1;
			end
			if (restart) begin
				hs_group = '0;
				hs_stage = '0;
				hs_served = WORD_W'(cfg.dance_a);
				r.changed = 1'b1;
			end
		end
		r.word = hs_served;
		r.done = hs_done;
		return r;
	endfunction

	// Mostly follows the handshake from the tracker's position, with some noise
	function automatic logic [ADDR_W-1:0] next_address();
		logic [ADDR_W-1:0] a;
		logic [WORD_W-1:0] w;
		int unsigned       r;
		r = $urandom_range(0, 99);
		a = {1'b1, 12'($urandom)};
		w = group_word(hs_group);
		if (r < 6) return {1'b0, 12'($urandom)};
		if (!climbing && r < 6 + noise_pct) begin
			case ($urandom_range(0, 3))
				0:       a = ADDR_SKIP;
				1:       a = ADDR_LOAD;
				2:       a = w[ADDR_W-1:0];
				default: a = 13'($urandom);
			endcase
			return a;
		end
		if (hs_stage < STG_SKIP_LAST) begin
			if ($urandom_range(0, 99) < (climbing ? 2 : 45)) a = ADDR_SKIP;
		end else if (hs_stage == STG_SKIP_LAST) begin
			if (climbing || $urandom_range(0, 99) < 85) a = ADDR_SKIP;
		end else if (hs_stage == STG_LOAD) begin
			if (hs_group != GRP_LAST || finish_ok) a = ADDR_LOAD;
			else if (a == ADDR_LOAD) a = ADDR_SKIP;
		end else if (hs_stage == STG_MATCH) begin
			if (hs_group <= GRP_LAST) a = w[ADDR_W-1:0];
		end
		return a;
	endfunction

	task automatic send_access(input logic [ADDR_W-1:0] a);
		int gap;
		gap = tx_calm ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bus_address <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_vectors.push_back(track_access(a));
		// new attempt from the top: sometimes chain group skips to reach the upper groups
		if (hs_group == '0 && hs_stage == '0)
			climbing = ($urandom_range(0, 99) < climb_pct);
	endtask

	task automatic run_items(input int n);
		repeat (n) send_access(next_address());
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_vectors.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DANCE_A: cfg.dance_a = value[ADDR_W-1:0];
			REG_DANCE_B: cfg.dance_b = value[ADDR_W-1:0];
			REG_DANCE_C: cfg.dance_c = value[ADDR_W-1:0];
			REG_DANCE_D: cfg.dance_d = value[ADDR_W-1:0];
			REG_FINAL:   cfg.final_vector = value[WORD_W-1:0];
			default:     ;
		endcase
	endtask

	task automatic load_config(input logic [ADDR_W-1:0] a, b, c, d, input logic [WORD_W-1:0] f);
		wait_drain();
		write_reg(REG_DANCE_A, APB_DW'(a));
		write_reg(REG_DANCE_B, APB_DW'(b));
		write_reg(REG_DANCE_C, APB_DW'(c));
		write_reg(REG_DANCE_D, APB_DW'(d));
		write_reg(REG_FINAL, APB_DW'(f));
	endtask

	function automatic logic [ADDR_W-1:0] random_dance();
		if ($urandom_range(0, 3) != 0) return {1'b1, 12'($urandom)};
		return 13'($urandom);
	endfunction

	// Reset settings: load, match, restarts, skip from stage three, ignored accesses
	task automatic test_directed();
		send_access(13'h0000);
		send_access(13'h0fff);
		send_access(13'h1000);
		send_access(ADDR_SKIP);
		send_access(ADDR_LOAD);
		send_access(DANCE_A_RST);
		send_access(ADDR_SKIP);
		send_access(13'h1234);
		send_access(13'h1001);
		send_access(13'h1002);
		send_access(13'h1003);
		send_access(ADDR_SKIP);
		send_access(ADDR_SKIP);
		send_access(ADDR_LOAD);
		send_access(13'h1000);
		send_access(ADDR_LOAD);
		send_access(13'h1fff);
		send_access(13'h1001);
		send_access(13'h1002);
		send_access(13'h1fff);
	endtask

	task automatic test_config_extremes();
		load_config('0, '0, '0, '0, '1);
		run_items(100);
		load_config('1, '1, '1, '1, '0);
		run_items(100);
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 5; p++) begin
			load_config(random_dance(), random_dance(), random_dance(), random_dance(),
				16'($urandom));
			tx_calm = (p == 2);
			rx_calm = (p == 2);
			noise_pct = $urandom_range(4, 20);
			run_items(130);
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Receiver holds off while the sender keeps pushing, so the input stalls
	task automatic test_backpressure();
		wait_drain();
		tx_calm = 1'b1;
		hold_requests++;
		run_items(40);
		tx_calm = 1'b0;
		run_items(20);
		wait_drain();
	endtask

	// Walk the whole handshake to done, then confirm later accesses change nothing
	task automatic test_finish();
		int guard;
		guard = 0;
		load_config(DANCE_A_RST, DANCE_B_RST, DANCE_C_RST, DANCE_D_RST, 16'($urandom));
		noise_pct = 0;
		climb_pct = 0;
		climbing = 1'b0;
		finish_ok = 1'b1;
		while (!hs_done && guard < 3000) begin
			send_access(next_address());
			guard++;
		end
		noise_pct = 50;
		run_items(25);
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			rx_hold = HOLD_CYCLES;
		end else if (rx_stall > 0) begin
			rx_stall--;
		end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
			rx_stall = idle_len();
		end
		out_ready <= arst_n && rx_hold == 0 && rx_stall == 0;
	end

	task automatic note_mismatch(input string what, input vec_result_t want,
			input vec_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected word %h changed %b done %b, got word %h changed %b done %b",
				$realtime, what, want.word, want.changed, want.done,
				got.word, got.changed, got.done);
	endtask

	always @(posedge clk) begin
		vec_result_t got;
		vec_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {vector_word, vector_changed, sequence_done};
			if (expected_vectors.size() == 0) begin
				note_mismatch("result with nothing pending", '0, got);
			end else begin
				want = expected_vectors.pop_front();
				if (got.word !== want.word || got.changed !== want.changed
						|| got.done !== want.done)
					note_mismatch("vector result", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random_phases();
		test_backpressure();
		test_finish();
		wait_drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_vectors.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/bbhd_pkg.sv
hw/rtl/bbhd_step.sv
hw/rtl/bus_boot_handshake_detector.sv
dv/tb_top.sv
